// File: sv/greedy_label_placer_unit_macros.svh
// assertion macros for the label placer checker
`ifndef GREEDY_LABEL_PLACER_UNIT_MACROS_SVH
`define GREEDY_LABEL_PLACER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define GLP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define GLP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/glp_pkg.sv
// shared constants, types and helpers of the label placer
package glp_pkg;
   localparam int MaxBoxesDef     = 24;
   localparam int ScreenPixelsDef = 240;
   localparam int HorizonRowDef   = 180;
   localparam int LabelHeightDef  = 9;
   localparam int LabelGap    = 3;
   localparam int ClockWidth  = 106;
   localparam int ClockHeight = 24;
   localparam int BandHeight  = 34;
   localparam int RingStep    = 10;
   localparam int RingLimit   = 150;
   localparam int SweepStart  = 26;
   // signed coordinate wide enough for all intermediate positions
   localparam int CoordW = 13;
   typedef logic signed [CoordW-1:0] coord_type;
   // sweep row counter, enough for the tallest sky the parameters allow
   localparam int RowW = 9;

   // candidate source codes
   localparam logic [2:0] SRC_CX = 3'd0, SRC_RX = 3'd1, SRC_LFX = 3'd2;
   localparam logic [2:0] SRC_ABOVE = 3'd3, SRC_BELOW = 3'd4, SRC_CY = 3'd5, SRC_XBELOW = 3'd6;

   // controller to datapath commands
   typedef struct packed {
      logic       load;      // capture input item
      logic       seed;      // clear table and seed reserved boxes
      logic       put_marker;
      logic       put_label;
      logic       cand_load; // register candidate position
      logic [1:0] phase;     // 0 fixed list, 1 rings, 2 sweep
      logic [2:0] fix_idx;
      logic [1:0] sub_idx;   // ring x index or sweep x index
      logic       ring_dn;   // ring below side
      logic [3:0] ring_d;    // ring number from 1
      logic [RowW-1:0] sweep_row;
      logic       test;      // compare registered candidate to table
      logic       finish;    // compose the result
      logic       found;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic opcode;
      logic new_frame;
      logic free;       // candidate tested free
   } sts_type;

   // fixed candidate list: x source, y source
   function automatic logic [5:0] fixed_src(input logic [1:0] cls, input logic [2:0] i);
      logic [2:0] xs, ys;
      xs = SRC_CX; ys = SRC_CY;
      case (cls)
         2'd0: begin
            case (i)
               3'd0: begin xs = SRC_CX;  ys = SRC_ABOVE; end
               3'd1: begin xs = SRC_LFX; ys = SRC_ABOVE; end
               3'd2: begin xs = SRC_RX;  ys = SRC_ABOVE; end
               3'd3: begin xs = SRC_CX;  ys = SRC_BELOW; end
               3'd4: begin xs = SRC_LFX; ys = SRC_BELOW; end
               3'd5: begin xs = SRC_RX;  ys = SRC_BELOW; end
               3'd6: begin xs = SRC_RX;  ys = SRC_CY; end
               default: begin xs = SRC_LFX; ys = SRC_CY; end
            endcase
         end
         2'd1: begin
            case (i)
               3'd0: begin xs = SRC_CX;  ys = SRC_XBELOW; end
               3'd1: begin xs = SRC_RX;  ys = SRC_XBELOW; end
               3'd2: begin xs = SRC_LFX; ys = SRC_XBELOW; end
               3'd3: begin xs = SRC_CX;  ys = SRC_ABOVE; end
               3'd4: begin xs = SRC_RX;  ys = SRC_ABOVE; end
               3'd5: begin xs = SRC_LFX; ys = SRC_ABOVE; end
               3'd6: begin xs = SRC_RX;  ys = SRC_CY; end
               default: begin xs = SRC_LFX; ys = SRC_CY; end
            endcase
         end
         default: begin
            case (i)
               3'd0: begin xs = SRC_RX;  ys = SRC_CY; end
               3'd1: begin xs = SRC_LFX; ys = SRC_CY; end
               3'd2: begin xs = SRC_CX;  ys = SRC_ABOVE; end
               3'd3: begin xs = SRC_CX;  ys = SRC_BELOW; end
               3'd4: begin xs = SRC_RX;  ys = SRC_ABOVE; end
               3'd5: begin xs = SRC_LFX; ys = SRC_ABOVE; end
               3'd6: begin xs = SRC_RX;  ys = SRC_BELOW; end
               default: begin xs = SRC_LFX; ys = SRC_BELOW; end
            endcase
         end
      endcase
      return {xs, ys};
   endfunction
endpackage

// File: sv/glp_ctrl.sv
// sequencer that walks the candidate list of the label placer
module glp_ctrl import glp_pkg::*; #(
   parameter int HORIZON_ROW  = HorizonRowDef,
   parameter int LABEL_HEIGHT = LabelHeightDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output ctl_type ctl
);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_SEED = 3'd1, ST_OP = 3'd2,
                          ST_CAND = 3'd3, ST_TEST = 3'd4, ST_DONE = 3'd5, ST_OUT = 3'd6;
   localparam int NumRings = RingLimit / RingStep;
   localparam int SweepStep = LABEL_HEIGHT + 2;
   localparam int SweepEnd  = HORIZON_ROW - LABEL_HEIGHT - 6;
   localparam int NumRows   = (SweepEnd > SweepStart)
                              ? (SweepEnd - SweepStart + SweepStep - 1) / SweepStep : 1;
   localparam int LastRow   = NumRows - 1;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] fix_ff, fix_in;
   logic [1:0] sub_ff, sub_in;
   logic       dn_ff, dn_in;
   logic [3:0] ring_ff, ring_in;
   logic [RowW-1:0] row_ff, row_in;
   logic       found_ff, found_in;
   logic       last;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);

   // last candidate of the whole order
   assign last = (phase_ff == 2'd2) && (sub_ff == 2'd2) && (row_ff == RowW'(LastRow));

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; fix_in = fix_ff; sub_in = sub_ff;
      dn_in = dn_ff; ring_in = ring_ff; row_in = row_ff; found_in = found_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            state_in = ST_SEED; phase_in = 2'd0; fix_in = 3'd0; sub_in = 2'd0;
            dn_in = 1'b0; ring_in = 4'd1; row_in = '0; found_in = 1'b0;
         end
         ST_SEED: state_in = ST_OP;
         ST_OP:   state_in = sts.opcode ? ST_CAND : ST_DONE;
         ST_CAND: state_in = ST_TEST;
         ST_TEST: begin
            if (sts.free) begin
               found_in = 1'b1; state_in = ST_DONE;
            end else if (last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_CAND;
               case (phase_ff)
                  2'd0: if (fix_ff == 3'd7) phase_in = 2'd1; else fix_in = fix_ff + 3'd1;
                  2'd1: begin
                     if (sub_ff != 2'd2) sub_in = sub_ff + 2'd1;
                     else begin
                        sub_in = 2'd0;
                        if (!dn_ff) dn_in = 1'b1;
                        else begin
                           dn_in = 1'b0;
                           if (ring_ff == 4'(NumRings)) phase_in = 2'd2;
                           else ring_in = ring_ff + 4'd1;
                        end
                     end
                  end
                  default: begin
                     if (sub_ff != 2'd2) sub_in = sub_ff + 2'd1;
                     else begin sub_in = 2'd0; row_in = row_ff + RowW'(1); end
                  end
               endcase
            end
         end
         ST_DONE: state_in = ST_OUT;
         ST_OUT:  if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; phase_ff <= 2'd0; fix_ff <= 3'd0; sub_ff <= 2'd0;
         dn_ff <= 1'b0; ring_ff <= 4'd1; row_ff <= '0; found_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; fix_ff <= fix_in; sub_ff <= sub_in;
         dn_ff <= dn_in; ring_ff <= ring_in; row_ff <= row_in; found_ff <= found_in;
      end
   end

   always_comb begin
      ctl = '0;
      ctl.load       = (state_ff == ST_IDLE) && req_tvalid;
      ctl.seed       = (state_ff == ST_SEED) && sts.new_frame;
      ctl.put_marker = (state_ff == ST_DONE) && !sts.opcode;
      ctl.cand_load  = (state_ff == ST_CAND);
      ctl.test       = (state_ff == ST_TEST);
      ctl.phase      = phase_ff;
      ctl.fix_idx    = fix_ff;
      ctl.sub_idx    = sub_ff;
      ctl.ring_dn    = dn_ff;
      ctl.ring_d     = ring_ff;
      ctl.sweep_row  = row_ff;
      ctl.finish     = (state_ff == ST_DONE);
      ctl.put_label  = (state_ff == ST_DONE) && sts.opcode && found_ff;
      ctl.found      = found_ff;
   end
endmodule

// File: sv/glp_datapath.sv
// box table, candidate generation and overlap test of the label placer
module glp_datapath import glp_pkg::*; #(
   parameter int MAX_BOXES     = MaxBoxesDef,
   parameter int SCREEN_PIXELS = ScreenPixelsDef,
   parameter int HORIZON_ROW   = HorizonRowDef,
   parameter int LABEL_HEIGHT  = LabelHeightDef
) (
   input  logic       clock,
   input  logic       reset,
   input  ctl_type    ctl,
   output sts_type    sts,
   input  logic [31:0] req_tdata,
   output logic       rsp_placed,
   output logic [7:0] rsp_label_x,
   output logic [7:0] rsp_label_y,
   output logic       rsp_table_full
);
   localparam int CntW = $clog2(MAX_BOXES + 1);
   localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int SweepStep = LABEL_HEIGHT + 2;
   localparam int SweepEnd  = HORIZON_ROW - LABEL_HEIGHT - 6;

   // input item
   logic       op_ff, nf_ff;
   logic [7:0] ax_ff, ay_ff, lw_ff;
   logic [3:0] e_ff;
   logic [1:0] cls_ff;
   // derived positions
   coord_type cx, cy, above, below, xbelow, rx, lfx, hix, hiy;
   coord_type px, py, tx, ty;
   coord_type tx_ff, ty_ff;
   logic      row_ok;
   logic [5:0] src;

   // box table
   coord_type bx_ff [MAX_BOXES];
   coord_type by_ff [MAX_BOXES];
   coord_type bw_ff [MAX_BOXES];
   coord_type bh_ff [MAX_BOXES];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [MAX_BOXES-1:0] hit;
   logic free_now;
   logic full;

   logic [3:0] e_eff;
   logic [7:0] lw_sat;
   assign e_eff  = (req_tdata[21:18] == 4'd0) ? 4'd1 : req_tdata[21:18];
   assign lw_sat = (int'(req_tdata[29:22]) > SCREEN_PIXELS) ? 8'(SCREEN_PIXELS)
                                                             : req_tdata[29:22];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff <= req_tdata[0]; nf_ff <= req_tdata[1];
         ax_ff <= req_tdata[9:2]; ay_ff <= req_tdata[17:10];
         e_ff <= e_eff; lw_ff <= lw_sat; cls_ff <= req_tdata[31:30];
      end
   end

   assign sts.opcode = op_ff;
   assign sts.new_frame = nf_ff;
   assign sts.free = free_now;

   always_comb begin
      cx     = coord_type'(ax_ff) - coord_type'(lw_ff >> 1);
      cy     = coord_type'(ay_ff) - coord_type'(LABEL_HEIGHT / 2);
      above  = coord_type'(ay_ff) - coord_type'(e_ff) - coord_type'(LABEL_HEIGHT + LabelGap);
      below  = coord_type'(ay_ff) + coord_type'(e_ff) + coord_type'(LabelGap);
      xbelow = coord_type'(ay_ff) + coord_type'(e_ff) + coord_type'(LABEL_HEIGHT + 4);
      rx     = coord_type'(ax_ff) + coord_type'(e_ff) + coord_type'(LabelGap);
      lfx    = coord_type'(ax_ff) - coord_type'(e_ff) - coord_type'(LabelGap)
               - coord_type'(lw_ff);
      hix    = coord_type'(SCREEN_PIXELS - 2) - coord_type'(lw_ff);
      hiy    = coord_type'(SCREEN_PIXELS - LABEL_HEIGHT - 2);
      src    = fixed_src(cls_ff, ctl.fix_idx);
      px = cx; py = cy;
      case (ctl.phase)
         2'd0: begin
            case (src[5:3])
               SRC_RX:  px = rx;
               SRC_LFX: px = lfx;
               default: px = cx;
            endcase
            case (src[2:0])
               SRC_ABOVE:  py = above;
               SRC_BELOW:  py = below;
               SRC_XBELOW: py = xbelow;
               default:    py = cy;
            endcase
         end
         2'd1: begin
            case (ctl.sub_idx)
               2'd1:    px = rx;
               2'd2:    px = lfx;
               default: px = cx;
            endcase
            py = ctl.ring_dn
               ? below + coord_type'(ctl.ring_d) * coord_type'(RingStep)
               : above - coord_type'(ctl.ring_d) * coord_type'(RingStep);
         end
         default: begin
            case (ctl.sub_idx)
               2'd0:    px = coord_type'(2);
               2'd1:    px = (coord_type'(SCREEN_PIXELS) - coord_type'(lw_ff)) >>> 1;
               default: px = hix;
            endcase
            py = coord_type'(SweepStart) + coord_type'(ctl.sweep_row) * coord_type'(SweepStep);
         end
      endcase
      tx = (px > hix) ? hix : px;
      if (tx < coord_type'(2)) tx = coord_type'(2);
      ty = (py > hiy) ? hiy : py;
      if (ty < coord_type'(2)) ty = coord_type'(2);
   end

   // sweep rows at or beyond the horizon limit are never free
   assign row_ok = (ctl.phase != 2'd2) || (ty_ff < coord_type'(SweepEnd));

   always_comb begin
      for (int i = 0; i < MAX_BOXES; i++) begin
         hit[i] = (CntW'(i) < cnt_ff) &&
                  (tx_ff < bx_ff[i] + bw_ff[i] + coord_type'(1)) &&
                  (tx_ff + coord_type'(lw_ff) + coord_type'(1) > bx_ff[i]) &&
                  (ty_ff < by_ff[i] + bh_ff[i] + coord_type'(1)) &&
                  (ty_ff + coord_type'(LABEL_HEIGHT + 1) > by_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cand_load) begin
         tx_ff <= tx; ty_ff <= ty;
      end
   end

   // combinational compare: free flag feeds the controller within the test state
   assign free_now = ctl.test && row_ok && (hit == '0);

   assign full = (cnt_ff == CntW'(MAX_BOXES));

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.seed) cnt_in = CntW'(2);
      else if ((ctl.put_marker || ctl.put_label) && !full) cnt_in = cnt_ff + CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (ctl.seed) begin
         bx_ff[0] <= '0; by_ff[0] <= coord_type'(HORIZON_ROW - 4);
         bw_ff[0] <= coord_type'(SCREEN_PIXELS); bh_ff[0] <= coord_type'(BandHeight);
         bx_ff[1] <= '0; by_ff[1] <= '0;
         bw_ff[1] <= coord_type'(ClockWidth); bh_ff[1] <= coord_type'(ClockHeight);
      end else if (ctl.put_marker && !full) begin
         bx_ff[IdxW'(cnt_ff)] <= coord_type'(ax_ff) - coord_type'(e_ff) - coord_type'(2);
         by_ff[IdxW'(cnt_ff)] <= coord_type'(ay_ff) - coord_type'(e_ff) - coord_type'(2);
         bw_ff[IdxW'(cnt_ff)] <= coord_type'({e_ff, 1'b0}) + coord_type'(5);
         bh_ff[IdxW'(cnt_ff)] <= coord_type'({e_ff, 1'b0}) + coord_type'(5);
      end else if (ctl.put_label && !full) begin
         bx_ff[IdxW'(cnt_ff)] <= tx_ff; by_ff[IdxW'(cnt_ff)] <= ty_ff;
         bw_ff[IdxW'(cnt_ff)] <= coord_type'(lw_ff);
         bh_ff[IdxW'(cnt_ff)] <= coord_type'(LABEL_HEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_placed <= !full && (!op_ff || ctl.found);
         rsp_label_x <= (op_ff && ctl.found && !full) ? tx_ff[7:0] : 8'd0;
         rsp_label_y <= (op_ff && ctl.found && !full) ? ty_ff[7:0] : 8'd0;
         rsp_table_full <= (cnt_in == CntW'(MAX_BOXES));
      end
   end
endmodule

// File: sv/greedy_label_placer_unit.sv
// top level of the greedy label placer
// channel | dir | tdata fields (low bit up)
// req_    | in  | opcode, new_frame, anchor_x, anchor_y, extent, label_width, order_class
// rsp_    | out | label_x, label_y; tuser: placed, table_full
// a marker item runs through the seed, opcode, done and output states; a label item
// adds a candidate and a test state per candidate trial, up to 137 trials
// each trial loads a clamped candidate then compares it against every box at once
// reset clears the box count; table entries are only read below the count
// a stalled result holds; the next item is taken once the result is transferred
module greedy_label_placer_unit import glp_pkg::*; #(
   parameter int MAX_BOXES     = MaxBoxesDef,
   parameter int SCREEN_PIXELS = ScreenPixelsDef,
   parameter int HORIZON_ROW   = HorizonRowDef,
   parameter int LABEL_HEIGHT  = LabelHeightDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // opcode, new_frame, anchor_x, anchor_y, extent,
                                   // label_width, order_class
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // label_x, label_y
   output logic [1:0]  rsp_tuser   // placed, table_full
);
   ctl_type ctl;
   sts_type sts;
   logic    placed, full;
   logic [7:0] lx, ly;

   glp_ctrl #(
      .HORIZON_ROW(HORIZON_ROW), .LABEL_HEIGHT(LABEL_HEIGHT)
   ) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .ctl
   );

   // free flag is evaluated in the test cycle itself
   glp_datapath #(
      .MAX_BOXES(MAX_BOXES), .SCREEN_PIXELS(SCREEN_PIXELS),
      .HORIZON_ROW(HORIZON_ROW), .LABEL_HEIGHT(LABEL_HEIGHT)
   ) u_dp (
      .clock, .reset, .ctl, .sts, .req_tdata,
      .rsp_placed(placed), .rsp_label_x(lx), .rsp_label_y(ly), .rsp_table_full(full)
   );

   assign rsp_tdata = {ly, lx};
   assign rsp_tuser = {full, placed};
endmodule

// File: sv/greedy_label_placer_unit_checker.sv
// port checker of the label placer with its bind
`include "greedy_label_placer_unit_macros.svh"
module greedy_label_placer_unit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   `GLP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")
   `GLP_ASSERT_IMP(a_one_item, clock, reset, rsp_tvalid, !req_tready, "item taken while result pending")
   `GLP_ASSERT_IMP(a_unplaced_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 16'd0, "unplaced result has a position")
   `GLP_ASSERT_NXT(a_no_instant, clock, reset, req_tvalid && req_tready, !rsp_tvalid, "result in the cycle after transfer")
endmodule

bind greedy_label_placer_unit greedy_label_placer_unit_checker u_chk (.*);
